// File: src/pu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the permutation unrank pipeline.
package pu_pkg;

    localparam int SYM_W             = 45;
    localparam int LEN_W             = 4;
    localparam int IDX_W             = 19;
    localparam int MAX_LETTERS_DEF   = 9;
    localparam int SYMBOL_BITS_DEF   = 5;

    typedef struct packed {
        logic [SYM_W-1:0] word_symbols;
        logic [LEN_W-1:0] word_length;
        logic [IDX_W-1:0] perm_rank;
    } t_in_word;

    typedef struct packed {
        logic [SYM_W-1:0] perm_symbols;
        logic [LEN_W-1:0] perm_length;
        logic             perm_valid;
    } t_out_word;

    typedef struct packed {
        logic             vld;
        logic             ok;
        logic [LEN_W-1:0] len;
    } t_ctl;

endpackage

// File: src/permutation_unrank_top.sv
`timescale 1ns / 1ps
// Top level of the permutation unrank pipeline.
// There is one register stage per divisor and one per output position.
// Throughput is one word per cycle while i_stall is low; a stalled output holds only the
// stages behind it that are full.
// Reset clears the valid bit of every stage; data registers are not reset.
module permutation_unrank_top
    import pu_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_word  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_word o_data
);

    localparam int DIG_W  = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
    localparam int POOL_W = MAX_LETTERS * SYMBOL_BITS;
    localparam int EXT_W  = (POOL_W > SYM_W) ? POOL_W : SYM_W;
    localparam int NSTG   = 2 * MAX_LETTERS;

    t_ctl                         w_ctl  [0:NSTG];
    logic [MAX_LETTERS*DIG_W-1:0] w_dig  [0:NSTG];
    logic [SYM_W-1:0]             w_word [0:MAX_LETTERS];
    logic [IDX_W-1:0]             w_idx  [0:MAX_LETTERS];
    logic [POOL_W-1:0]            w_pool [MAX_LETTERS:NSTG];
    logic [POOL_W-1:0]            w_res  [MAX_LETTERS:NSTG];
    logic [NSTG-1:0]              w_adv;
    logic [EXT_W-1:0]             word_ext;
    logic [EXT_W-1:0]             res_ext;

    assign w_ctl[0].vld = i_valid;
    assign w_ctl[0].ok  = (i_data.word_length != '0)
                          && (i_data.word_length <= LEN_W'(MAX_LETTERS));
    assign w_ctl[0].len = i_data.word_length;
    assign w_word[0]    = i_data.word_symbols;
    assign w_idx[0]     = i_data.perm_rank;
    assign w_dig[0]     = '0;

    assign w_adv[NSTG-1] = !w_ctl[NSTG].vld || !i_stall;
    genvar s;
    generate
        for (s = 0; s < NSTG - 1; s++) begin : g_adv
            assign w_adv[s] = !w_ctl[s+1].vld || w_adv[s+1];
        end
    endgenerate
    assign o_stall = !w_adv[0];

    generate
        for (s = 0; s < MAX_LETTERS; s++) begin : g_div
            pu_div_stage #(
                .MAX_LETTERS (MAX_LETTERS),
                .DIG_W       (DIG_W),
                .DIVISOR     (s + 1)
            ) u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv[s]),
                .i_ctl   (w_ctl[s]),
                .i_word  (w_word[s]),
                .i_idx   (w_idx[s]),
                .i_dig   (w_dig[s]),
                .o_ctl   (w_ctl[s+1]),
                .o_word  (w_word[s+1]),
                .o_idx   (w_idx[s+1]),
                .o_dig   (w_dig[s+1])
            );
        end
    endgenerate

    assign word_ext            = EXT_W'(w_word[MAX_LETTERS]);
    assign w_pool[MAX_LETTERS] = word_ext[POOL_W-1:0];
    assign w_res[MAX_LETTERS]  = '0;

    generate
        for (s = 0; s < MAX_LETTERS; s++) begin : g_sel
            pu_sel_stage #(
                .MAX_LETTERS (MAX_LETTERS),
                .SYMBOL_BITS (SYMBOL_BITS),
                .DIG_W       (DIG_W),
                .POS         (s)
            ) u_sel (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (w_adv[MAX_LETTERS+s]),
                .i_ctl   (w_ctl[MAX_LETTERS+s]),
                .i_dig   (w_dig[MAX_LETTERS+s]),
                .i_pool  (w_pool[MAX_LETTERS+s]),
                .i_res   (w_res[MAX_LETTERS+s]),
                .o_ctl   (w_ctl[MAX_LETTERS+s+1]),
                .o_dig   (w_dig[MAX_LETTERS+s+1]),
                .o_pool  (w_pool[MAX_LETTERS+s+1]),
                .o_res   (w_res[MAX_LETTERS+s+1])
            );
        end
    endgenerate

    assign res_ext = EXT_W'(w_res[NSTG]);
    assign o_valid = w_ctl[NSTG].vld;

    always_comb begin
        if (w_ctl[NSTG].ok) begin
            o_data.perm_symbols = res_ext[SYM_W-1:0];
            o_data.perm_length  = w_ctl[NSTG].len;
            o_data.perm_valid   = 1'b1;
        end else begin
            o_data = '0;
        end
    end

endmodule

// File: src/pu_div_stage.sv
`timescale 1ns / 1ps
// One factoradic digit stage: divides the index by a fixed divisor.
module pu_div_stage
    import pu_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF,
    parameter int DIG_W       = 4,
    parameter int DIVISOR     = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  t_ctl                         i_ctl,
    input  logic [SYM_W-1:0]             i_word,
    input  logic [IDX_W-1:0]             i_idx,
    input  logic [MAX_LETTERS*DIG_W-1:0] i_dig,
    output t_ctl                         o_ctl,
    output logic [SYM_W-1:0]             o_word,
    output logic [IDX_W-1:0]             o_idx,
    output logic [MAX_LETTERS*DIG_W-1:0] o_dig
);

    localparam int                PROD_W = 2 * IDX_W + 1;
    localparam logic [IDX_W:0]    RECIP  = (IDX_W + 1)'((64'd1 << IDX_W) / DIVISOR);
    localparam logic [IDX_W-1:0]  DIV_C  = IDX_W'(DIVISOR);

    logic [PROD_W-1:0]            prod;
    logic [IDX_W-1:0]             q_est;
    logic [IDX_W-1:0]             back;
    logic [IDX_W-1:0]             rem_est;
    logic [IDX_W-1:0]             quot;
    logic [IDX_W-1:0]             rem;
    t_ctl                         n_ctl;
    logic [MAX_LETTERS*DIG_W-1:0] n_dig;

    t_ctl                         r_ctl;
    logic [SYM_W-1:0]             r_word;
    logic [IDX_W-1:0]             r_idx;
    logic [MAX_LETTERS*DIG_W-1:0] r_dig;

    // The reciprocal estimate is at most one below the true quotient.
    always_comb begin
        prod    = PROD_W'(i_idx) * PROD_W'(RECIP);
        q_est   = prod[IDX_W +: IDX_W];
        back    = q_est * DIV_C;
        rem_est = i_idx - back;
        if (rem_est >= DIV_C) begin
            quot = q_est + 1'b1;
            rem  = rem_est - DIV_C;
        end else begin
            quot = q_est;
            rem  = rem_est;
        end
        n_dig = i_dig;
        n_dig[(DIVISOR-1)*DIG_W +: DIG_W] = rem[DIG_W-1:0];
        n_ctl = i_ctl;
        if (i_ctl.len == LEN_W'(DIVISOR) && quot != '0) begin
            n_ctl.ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.vld) begin
            r_word <= i_word;
            r_idx  <= quot;
            r_dig  <= n_dig;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_word = r_word;
    assign o_idx  = r_idx;
    assign o_dig  = r_dig;

endmodule

// File: src/pu_sel_stage.sv
`timescale 1ns / 1ps
// One output position: picks a symbol from the pool by its digit and removes it.
module pu_sel_stage
    import pu_pkg::*;
#(
    parameter int MAX_LETTERS = MAX_LETTERS_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
    parameter int DIG_W       = 4,
    parameter int POS         = 0
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  t_ctl                               i_ctl,
    input  logic [MAX_LETTERS*DIG_W-1:0]       i_dig,
    input  logic [MAX_LETTERS*SYMBOL_BITS-1:0] i_pool,
    input  logic [MAX_LETTERS*SYMBOL_BITS-1:0] i_res,
    output t_ctl                               o_ctl,
    output logic [MAX_LETTERS*DIG_W-1:0]       o_dig,
    output logic [MAX_LETTERS*SYMBOL_BITS-1:0] o_pool,
    output logic [MAX_LETTERS*SYMBOL_BITS-1:0] o_res
);

    localparam int POOL_W = MAX_LETTERS * SYMBOL_BITS;

    logic                   active;
    logic [LEN_W-1:0]       rem_cnt;
    logic [DIG_W-1:0]       sel;
    logic [SYMBOL_BITS-1:0] sym;
    logic [POOL_W-1:0]      shifted;
    logic [POOL_W-1:0]      n_pool;
    logic [POOL_W-1:0]      n_res;

    t_ctl                         r_ctl;
    logic [MAX_LETTERS*DIG_W-1:0] r_dig;
    logic [POOL_W-1:0]            r_pool;
    logic [POOL_W-1:0]            r_res;

    always_comb begin
        active  = i_ctl.ok && (i_ctl.len > LEN_W'(POS));
        rem_cnt = i_ctl.len - LEN_W'(POS + 1);
        sel     = '0;
        for (int k = 0; k < MAX_LETTERS; k++) begin
            if (LEN_W'(k) == rem_cnt) begin
                sel = i_dig[k*DIG_W +: DIG_W];
            end
        end
        sym = '0;
        for (int k = 0; k < MAX_LETTERS; k++) begin
            if (DIG_W'(k) == sel) begin
                sym = i_pool[k*SYMBOL_BITS +: SYMBOL_BITS];
            end
        end
        shifted = i_pool >> SYMBOL_BITS;
        for (int k = 0; k < MAX_LETTERS; k++) begin
            if (DIG_W'(k) < sel) begin
                n_pool[k*SYMBOL_BITS +: SYMBOL_BITS] = i_pool[k*SYMBOL_BITS +: SYMBOL_BITS];
            end else begin
                n_pool[k*SYMBOL_BITS +: SYMBOL_BITS] = shifted[k*SYMBOL_BITS +: SYMBOL_BITS];
            end
        end
        n_res = i_res;
        if (active) begin
            n_res[POS*SYMBOL_BITS +: SYMBOL_BITS] = sym;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.vld) begin
            r_dig  <= i_dig;
            r_pool <= n_pool;
            r_res  <= n_res;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_dig  = r_dig;
    assign o_pool = r_pool;
    assign o_res  = r_res;

endmodule
